>>> rtl/tpt_pkg.sv
package tpt_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int MAX_RES        = 16;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_GET  = 2'd1;
    localparam logic [1:0] MODE_FREE = 2'd2;
    localparam logic [1:0] MODE_SET  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_NULL_CB = 2'd2;
    localparam logic [1:0] ST_NOT_USE = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  handle_out;
        logic        expired;
        logic [7:0]  expired_callback;
        logic [15:0] expired_tag;
        logic        last;
    } rec_t;

    // list update request from the sequencer
    typedef struct packed {
        logic get_en;
        logic rel_en;
    } list_cmd_t;

endpackage

>>> rtl/tpt_if.sv
interface tpt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [3:0]  handle;
    logic [7:0]  callback_id;
    logic [15:0] owner_tag;
    logic [23:0] tick_count;
    modport source (output valid, mode, handle, callback_id, owner_tag, tick_count,
                    input ready);
    modport sink (input valid, mode, handle, callback_id, owner_tag, tick_count,
                  output ready);
endinterface

interface tpt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  handle_out;
    logic        expired;
    logic [7:0]  expired_callback;
    logic [15:0] expired_tag;
    logic        last;
    modport source (output valid, status, handle_out, expired, expired_callback,
                    expired_tag, last, input ready);
    modport sink (input valid, status, handle_out, expired, expired_callback,
                  expired_tag, last, output ready);
endinterface

>>> rtl/tpt_ram.sv
module tpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/tpt_list.sv
module tpt_list
    import tpt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    localparam int IW = $clog2(NUM_TIMERS + 1),
    localparam int EW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  list_cmd_t             cmd,
    input  logic [IW-1:0]         rel_idx,
    input  logic [IW-1:0]         rd_idx,
    output logic [IW-1:0]         fwd_sel,
    output logic [IW-1:0]         active_head,
    output logic [IW-1:0]         free_head,
    output logic [NUM_TIMERS-1:0] active
);
    localparam logic [IW-1:0] NIL = IW'(NUM_TIMERS);

    logic [IW-1:0]         fwd_reg [NUM_TIMERS];
    logic [IW-1:0]         bwd_reg [NUM_TIMERS];
    logic [IW-1:0]         head_reg;
    logic [IW-1:0]         fhead_reg;
    logic [NUM_TIMERS-1:0] act_reg;
    logic [IW-1:0]         prv;
    logic [IW-1:0]         nxt;
    logic                  prv_ok;
    logic                  nxt_ok;
    logic                  head_ok;

    assign active_head = head_reg;
    assign free_head   = fhead_reg;
    assign active      = act_reg;
    assign fwd_sel     = fwd_reg[EW'(rd_idx)];
    assign prv         = bwd_reg[EW'(rel_idx)];
    assign nxt         = fwd_reg[EW'(rel_idx)];
    assign prv_ok      = prv < NIL;
    assign nxt_ok      = nxt < NIL;
    assign head_ok     = head_reg < NIL;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                fwd_reg[i] <= (i == 0) ? NIL : IW'(i - 1);
            end
            head_reg  <= NIL;
            fhead_reg <= IW'(NUM_TIMERS - 1);
            act_reg   <= '0;
        end
        else if (cmd.get_en)
        begin
            fhead_reg                  <= fwd_reg[EW'(fhead_reg)];
            act_reg[EW'(fhead_reg)]    <= 1'b1;
            fwd_reg[EW'(fhead_reg)]    <= head_reg;
            head_reg                   <= fhead_reg;
        end
        else if (cmd.rel_en)
        begin
            if (prv_ok)
            begin
                fwd_reg[EW'(prv)] <= nxt;
            end
            else
            begin
                head_reg <= nxt;
            end
            fwd_reg[EW'(rel_idx)] <= fhead_reg;
            fhead_reg             <= rel_idx;
            act_reg[EW'(rel_idx)] <= 1'b0;
        end
    end

    // backward links: undefined until written
    always_ff @(posedge clk)
    begin
        if (cmd.get_en)
        begin
            bwd_reg[EW'(fhead_reg)] <= NIL;
            if (head_ok)
            begin
                bwd_reg[EW'(head_reg)] <= fhead_reg;
            end
        end
        else if (cmd.rel_en && nxt_ok)
        begin
            bwd_reg[EW'(nxt)] <= prv_ok ? prv : NIL;
        end
    end

    a_get_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.get_en |-> (fhead_reg < NIL) && !act_reg[EW'(fhead_reg)])
        else $error("get from empty or busy free head");
    a_rel_act: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rel_en |-> act_reg[EW'(rel_idx)])
        else $error("release of inactive timer");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.get_en && cmd.rel_en))
        else $error("get and release together");
endmodule

>>> rtl/timer_pool_tick_manager.sv
// Timer pool with free stack and active list; counts, callbacks and tags in RAM.
// Get, free and set: the result is registered in S_EMIT and offered once the output is free.
// Tick: each active timer walked takes a RAM read (S_RD), then a decrement or expire
//   (S_EV); the walk ends at the list end or after NUM_TIMERS timers, then S_FIN closes.
// One input transaction is in work at a time; output stalls hold the walk.
// rst_n (async, active low) empties the active list and rebuilds the free stack.
module timer_pool_tick_manager
    import tpt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tpt_in_if.sink    req,
    tpt_out_if.source rsp
);
    localparam int IW = $clog2(NUM_TIMERS + 1);
    localparam int EW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int NW = $clog2(MAX_RES + 1);
    localparam logic [IW-1:0] NIL = IW'(NUM_TIMERS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;  // RAM read of current timer
    localparam logic [2:0] S_EV   = 3'd2;  // decrement or expire
    localparam logic [2:0] S_FIN  = 3'd3;  // close the tick
    localparam logic [2:0] S_EMIT = 3'd4;  // single-record result

    logic [2:0]            state_reg, state_next;
    logic [IW-1:0]         t_reg, t_next;
    logic [IW-1:0]         steps_reg, steps_next;
    logic [NW-1:0]         n_reg, n_next;
    logic                  held_valid_reg, held_valid_next;
    rec_t                  held_reg, held_next;
    rec_t                  pend_reg, pend_next;
    logic                  out_valid_reg, out_valid_next;
    rec_t                  out_reg, out_next;

    list_cmd_t             lcmd;
    logic [IW-1:0]         rel_idx;
    logic [IW-1:0]         fwd_sel;
    logic [IW-1:0]         active_head;
    logic [IW-1:0]         free_head;
    logic [NUM_TIMERS-1:0] active;

    logic                  cc_we;
    logic [EW-1:0]         cc_waddr;
    logic [31:0]           cc_wdata;
    logic [31:0]           cc_rdata;
    logic                  tag_we;
    logic [15:0]           tag_rdata;

    logic                  accept;
    logic                  out_free;
    logic [IW-1:0]         h_idx;
    logic                  h_ok;
    logic                  h_act;
    rec_t                  rec;

    tpt_list #(.NUM_TIMERS(NUM_TIMERS)) u_list (
        .clk(clk), .rst_n(rst_n), .cmd(lcmd), .rel_idx(rel_idx), .rd_idx(t_reg),
        .fwd_sel(fwd_sel), .active_head(active_head), .free_head(free_head),
        .active(active)
    );

    // {count, callback}
    tpt_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_cc_ram (
        .clk(clk), .we(cc_we), .waddr(cc_waddr), .wdata(cc_wdata),
        .raddr(EW'(t_reg)), .rdata(cc_rdata)
    );

    tpt_ram #(.WIDTH(16), .DEPTH(NUM_TIMERS)) u_tag_ram (
        .clk(clk), .we(tag_we), .waddr(EW'(free_head)), .wdata(req.owner_tag),
        .raddr(EW'(t_reg)), .rdata(tag_rdata)
    );

    assign req.ready   = (state_reg == S_IDLE);
    assign accept      = req.valid && req.ready;
    assign out_free    = !out_valid_reg || rsp.ready;
    assign h_idx       = IW'(req.handle);
    assign h_ok        = 32'(req.handle) < NUM_TIMERS;
    assign h_act       = h_ok && active[EW'(h_idx)];

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_reg.status;
    assign rsp.handle_out       = out_reg.handle_out;
    assign rsp.expired          = out_reg.expired;
    assign rsp.expired_callback = out_reg.expired_callback;
    assign rsp.expired_tag      = out_reg.expired_tag;
    assign rsp.last             = out_reg.last;

    always_comb
    begin
        state_next      = state_reg;
        t_next          = t_reg;
        steps_next      = steps_reg;
        n_next          = n_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_next        = out_reg;
        lcmd            = '0;
        rel_idx         = h_idx;
        cc_we           = 1'b0;
        cc_waddr        = EW'(t_reg);
        cc_wdata        = {cc_rdata[31:8] - 24'd1, cc_rdata[7:0]};
        tag_we          = 1'b0;
        rec             = '0;
        rec.last        = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.mode)
                        MODE_TICK:
                        begin
                            n_next          = '0;
                            steps_next      = '0;
                            held_valid_next = 1'b0;
                            t_next          = active_head;
                            state_next      = (active_head < NIL) ? S_RD : S_FIN;
                        end
                        MODE_GET:
                        begin
                            if (req.callback_id == 8'd0)
                            begin
                                rec.status = ST_NULL_CB;
                            end
                            else if (!(free_head < NIL))
                            begin
                                rec.status = ST_NONE;
                            end
                            else
                            begin
                                rec.status     = ST_OK;
                                rec.handle_out = 4'(free_head);
                                lcmd.get_en    = 1'b1;
                                cc_we          = 1'b1;
                                cc_waddr       = EW'(free_head);
                                cc_wdata       = {req.tick_count, req.callback_id};
                                tag_we         = 1'b1;
                            end
                            pend_next  = rec;
                            state_next = S_EMIT;
                        end
                        MODE_FREE:
                        begin
                            rec.handle_out = req.handle;
                            if (!h_act)
                            begin
                                rec.status = ST_NOT_USE;
                            end
                            else
                            begin
                                rec.status  = ST_OK;
                                lcmd.rel_en = 1'b1;
                            end
                            pend_next  = rec;
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            rec.handle_out = req.handle;
                            if (req.callback_id == 8'd0)
                            begin
                                rec.status = ST_NULL_CB;
                            end
                            else if (!h_act)
                            begin
                                rec.status = ST_NOT_USE;
                            end
                            else
                            begin
                                rec.status = ST_OK;
                                cc_we      = 1'b1;
                                cc_waddr   = EW'(h_idx);
                                cc_wdata   = {req.tick_count, req.callback_id};
                            end
                            pend_next  = rec;
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_EV;
            end
            S_EV:
            begin
                logic advance;
                advance = 1'b1;
                if (cc_rdata[31:8] != 24'd0)
                begin
                    cc_we = 1'b1;
                end
                else if (32'(n_reg) < MAX_RES)
                begin
                    if (held_valid_reg && !out_free)
                    begin
                        advance = 1'b0;
                    end
                    else
                    begin
                        if (held_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = held_reg;
                        end
                        held_valid_next            = 1'b1;
                        held_next                  = '0;
                        held_next.status           = ST_OK;
                        held_next.handle_out       = 4'(t_reg);
                        held_next.expired          = 1'b1;
                        held_next.expired_callback = cc_rdata[7:0];
                        held_next.expired_tag      = tag_rdata;
                        lcmd.rel_en                = 1'b1;
                        rel_idx                    = t_reg;
                        n_next                     = n_reg + NW'(1);
                    end
                end
                if (advance)
                begin
                    steps_next = steps_reg + IW'(1);
                    t_next     = fwd_sel;
                    if (!(fwd_sel < NIL) || (32'(steps_reg) + 1 >= NUM_TIMERS))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = held_valid_reg ? held_reg : rec;
                    out_next.last  = 1'b1;
                    held_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = pend_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            n_reg          <= '0;
            steps_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
            n_reg          <= n_next;
            steps_reg      <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        held_reg <= held_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    a_held_tick: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> (state_reg == S_RD || state_reg == S_EV || state_reg == S_FIN))
        else $error("held expiry outside tick walk");
    a_n_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(n_reg) <= MAX_RES)
        else $error("expiry count over limit");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result changed");
    a_ev_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EV) |-> ($past(state_reg) == S_RD || $past(state_reg) == S_EV))
        else $error("evaluate without RAM read");
endmodule

>>> bench/tpt_checker.sv
`timescale 1ns / 100ps

// Watches both channels, keeps a shadow of the timer pool and compares every
// response record against the oldest predicted one.
module tpt_checker
    import tpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tpt_in_if    req,
    tpt_out_if   rsp,
    output int   fail_count,
    output int   pending
);

    localparam int NT  = NUM_TIMERS_DEF;
    localparam int NIL = NUM_TIMERS_DEF;

    // shadow pool
    logic        shd_active [NT];
    logic [23:0] shd_count  [NT];
    logic [7:0]  shd_cb     [NT];
    logic [15:0] shd_tag    [NT];
    int          shd_next   [NT];
    int          shd_prev   [NT];
    int          shd_head;
    int          shd_free;

    rec_t expected_recs[$];

    assign pending = expected_recs.size();

    function automatic rec_t make_rec(logic [1:0] st, logic [3:0] h, logic ex,
                                      logic [7:0] cb, logic [15:0] tag, logic lst);
        rec_t r;
        r.status           = st;
        r.handle_out       = h;
        r.expired          = ex;
        r.expired_callback = cb;
        r.expired_tag      = tag;
        r.last             = lst;
        return r;
    endfunction

    function automatic void pool_clear();
        for (int i = 0; i < NT; i++)
        begin
            shd_active[i] = 1'b0;
            shd_count[i]  = '0;
            shd_cb[i]     = '0;
            shd_tag[i]    = '0;
            shd_next[i]   = (i == 0) ? NIL : i - 1;
            shd_prev[i]   = 0;
        end
        shd_head = NIL;
        shd_free = NT - 1;
    endfunction

    // unlink from the active list, push on the free stack
    function automatic void unlink_timer(int t);
        int p;
        int n;
        p = shd_prev[t];
        n = shd_next[t];
        if (p < NT)
            shd_next[p] = n;
        else
            shd_head = n;
        if (n < NT)
            shd_prev[n] = (p < NT) ? p : NIL;
        shd_next[t]   = shd_free;
        shd_free      = t;
        shd_active[t] = 1'b0;
    endfunction

    function automatic void timer_step(logic [1:0] md, logic [3:0] h, logic [7:0] cb,
                                       logic [15:0] tag, logic [23:0] cnt);
        int   t;
        int   nx;
        int   walked;
        int   hits;
        rec_t r;
        case (md)
            MODE_TICK:
            begin
                t      = shd_head;
                walked = 0;
                hits   = 0;
                while (t < NT && walked < NT)
                begin
                    nx = shd_next[t];
                    if (shd_count[t] != 0)
                        shd_count[t] = shd_count[t] - 1;
                    else if (hits < MAX_RES)
                    begin
                        expected_recs.push_back(make_rec(ST_OK, t[3:0], 1'b1, shd_cb[t],
                                                         shd_tag[t], 1'b0));
                        hits++;
                        unlink_timer(t);
                    end
                    t = nx;
                    walked++;
                end
                if (hits == 0)
                    expected_recs.push_back(make_rec(ST_OK, '0, 1'b0, '0, '0, 1'b1));
                else
                begin
                    r      = expected_recs.pop_back();
                    r.last = 1'b1;
                    expected_recs.push_back(r);
                end
            end
            MODE_GET:
            begin
                if (cb == 0)
                    expected_recs.push_back(make_rec(ST_NULL_CB, '0, 1'b0, '0, '0, 1'b1));
                else if (shd_free >= NT)
                    expected_recs.push_back(make_rec(ST_NONE, '0, 1'b0, '0, '0, 1'b1));
                else
                begin
                    t             = shd_free;
                    shd_free      = shd_next[t];
                    shd_active[t] = 1'b1;
                    shd_count[t]  = cnt;
                    shd_cb[t]     = cb;
                    shd_tag[t]    = tag;
                    shd_prev[t]   = NIL;
                    shd_next[t]   = shd_head;
                    if (shd_head < NT)
                        shd_prev[shd_head] = t;
                    shd_head = t;
                    expected_recs.push_back(make_rec(ST_OK, t[3:0], 1'b0, '0, '0, 1'b1));
                end
            end
            MODE_FREE:
            begin
                if (!shd_active[h])
                    expected_recs.push_back(make_rec(ST_NOT_USE, h, 1'b0, '0, '0, 1'b1));
                else
                begin
                    unlink_timer(h);
                    expected_recs.push_back(make_rec(ST_OK, h, 1'b0, '0, '0, 1'b1));
                end
            end
            default:
            begin
                // null callback is checked before ownership
                if (cb == 0)
                    expected_recs.push_back(make_rec(ST_NULL_CB, h, 1'b0, '0, '0, 1'b1));
                else if (!shd_active[h])
                    expected_recs.push_back(make_rec(ST_NOT_USE, h, 1'b0, '0, '0, 1'b1));
                else
                begin
                    shd_cb[h]    = cb;
                    shd_count[h] = cnt;
                    expected_recs.push_back(make_rec(ST_OK, h, 1'b0, '0, '0, 1'b1));
                end
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rec_t want;
        if (!rst_n)
        begin
            pool_clear();
            expected_recs.delete();
            fail_count <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_recs.size() == 0)
                begin
                    $error("unexpected response transaction: status %0h handle_out %0h",
                           rsp.status, rsp.handle_out);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_recs.pop_front();
                    if (rsp.status !== want.status ||
                        rsp.handle_out !== want.handle_out ||
                        rsp.expired !== want.expired ||
                        rsp.expired_callback !== want.expired_callback ||
                        rsp.expired_tag !== want.expired_tag ||
                        rsp.last !== want.last)
                        fail_count <= fail_count + 1;
                    if (rsp.status !== want.status)
                        $error("status: expected %0h got %0h", want.status, rsp.status);
                    if (rsp.handle_out !== want.handle_out)
                        $error("handle_out: expected %0h got %0h",
                               want.handle_out, rsp.handle_out);
                    if (rsp.expired !== want.expired)
                        $error("expired: expected %0h got %0h", want.expired, rsp.expired);
                    if (rsp.expired_callback !== want.expired_callback)
                        $error("expired_callback: expected %0h got %0h",
                               want.expired_callback, rsp.expired_callback);
                    if (rsp.expired_tag !== want.expired_tag)
                        $error("expired_tag: expected %0h got %0h",
                               want.expired_tag, rsp.expired_tag);
                    if (rsp.last !== want.last)
                        $error("last: expected %0h got %0h", want.last, rsp.last);
                end
            end
            if (req.valid && req.ready)
                timer_step(req.mode, req.handle, req.callback_id, req.owner_tag,
                           req.tick_count);
        end
    end

endmodule

>>> bench/tb_timer_pool_tick_manager.sv
`timescale 1ns / 100ps

// Top level: clock, reset, request stimulus, response back-pressure, verdict.
module tb_timer_pool_tick_manager;
    import tpt_pkg::*;

    localparam int  RANDOM_ITEMS = 350;
    localparam int  CALM_ITEMS   = 60;       // tail of the run with no idling
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  DRAIN_CYCLES = 60;       // longer than a tick walk of a full list

    logic clk;
    logic rst_n;
    logic calm;        // no idling on either side
    int   fail_count;
    int   pending;
    int   cycles;

    tpt_in_if  req ();
    tpt_out_if rsp ();

    timer_pool_tick_manager i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    tpt_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Response side: ready held high for a while, then dropped for a burst.
    initial
    begin
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (calm)
                rsp.ready <= 1'b1;
            else if (rsp.ready)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    rsp.ready <= 1'b0;
                    repeat ($urandom_range(1, 13)) @(posedge clk);
                    rsp.ready <= 1'b1;
                end
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // One request transaction; returns at the edge where it was accepted.
    // A random gap may come first unless the run is in its calm tail.
    task automatic send_req(logic [1:0] md, logic [3:0] h, logic [7:0] cb,
                            logic [15:0] tag, logic [23:0] cnt);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.mode        <= md;
        req.handle      <= h;
        req.callback_id <= cb;
        req.owner_tag   <= tag;
        req.tick_count  <= cnt;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // Random transaction: mostly gets with short counts and ticks so timers
    // really cycle through expiry; frees and sets hit random handles.
    task automatic send_random();
        int          pick;
        logic [1:0]  md;
        logic [7:0]  cb;
        logic [23:0] cnt;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            md = MODE_GET;
        else if (pick < 65)
            md = MODE_TICK;
        else if (pick < 82)
            md = MODE_FREE;
        else
            md = MODE_SET;
        cb  = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        cnt = ($urandom_range(0, 15) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4));
        send_req(md, 4'($urandom_range(0, 15)), cb, 16'($urandom), cnt);
    endtask

    initial
    begin
        calm            = 1'b0;
        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.mode        = MODE_TICK;
        req.handle      = '0;
        req.callback_id = '0;
        req.owner_tag   = '0;
        req.tick_count  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-list tick, null callbacks, timers not in use
        send_req(MODE_TICK, 4'd0, 8'd0, 16'd0, 24'd0);
        send_req(MODE_GET, 4'd0, 8'd0, 16'hFFFF, 24'd5);
        send_req(MODE_SET, 4'd3, 8'd0, 16'd0, 24'd1);
        send_req(MODE_FREE, 4'd5, 8'd1, 16'd0, 24'd0);
        send_req(MODE_SET, 4'd15, 8'hFF, 16'd0, 24'hFFFFFF);
        // drain the free stack; counts alternate zero and maximum
        for (int i = 0; i < 16; i++)
            send_req(MODE_GET, 4'd0, (i % 2) ? 8'hFF : 8'h01,
                     (i % 2) ? 16'hFFFF : 16'h0000,
                     (i % 2) ? 24'hFFFFFF : 24'd0);
        // pool empty
        send_req(MODE_GET, 4'd0, 8'hA5, 16'h1234, 24'd3);
        // half the pool expires in one tick
        send_req(MODE_TICK, 4'd0, 8'd0, 16'd0, 24'd0);
        // set a live timer, then a double free
        send_req(MODE_SET, 4'd14, 8'h5A, 16'd0, 24'd0);
        send_req(MODE_FREE, 4'd14, 8'd0, 16'd0, 24'd0);
        send_req(MODE_FREE, 4'd14, 8'd0, 16'd0, 24'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // hold off until the pipeline is empty once, midway
            if (i == RANDOM_ITEMS / 2)
            begin
                req.valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            if (i == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            send_random();
        end
        req.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
